### rtl/spc_pkg.sv
// Shared types and constants for the straw position correction unit.
// Holds the item structs, coefficient entry layout and fixed-point widths.
// No dependencies.
package spc_pkg;

   localparam int NUM_STRAWS = 4096;
   localparam int STRAW_AW   = $clog2(NUM_STRAWS);

   localparam int STRAW_W  = 12;
   localparam int POS_W    = 19;
   localparam int POS_FRAC = 8;
   localparam int COEF_W   = 48;
   localparam int RES_W    = 11;
   localparam int FRAC_W   = 32;
   localparam int ACC_W    = 56;
   localparam int HI_W     = ACC_W - FRAC_W;
   localparam int SUM_W    = ACC_W + 2;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_CORRECT = 1'b1;

   localparam logic [RES_W-1:0] RES_RESET = RES_W'(512);

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef struct packed {
      logic                      op;
      logic [STRAW_W-1:0]        straw_id;
      logic [POS_W-1:0]          pos;
      logic signed [COEF_W-1:0]  coef_a;
      logic signed [COEF_W-1:0]  coef_b;
      logic signed [COEF_W-1:0]  coef_c;
      logic signed [COEF_W-1:0]  coef_d;
   } spc_req_type;

   typedef struct packed {
      logic [STRAW_W-1:0] straw_out;
      logic [RES_W-1:0]   pixel_pos;
      logic               clamp_low;
      logic               clamp_high;
   } spc_rsp_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
      logic signed [COEF_W-1:0] coef_c;
      logic signed [COEF_W-1:0] coef_d;
   } spc_coef_type;

   // Horner work item: acc is the running value, add0 the next addend.
   typedef struct packed {
      logic [STRAW_W-1:0]      straw;
      logic [POS_W-1:0]        pos;
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] add0;
      logic signed [ACC_W-1:0] add1;
      logic signed [ACC_W-1:0] add2;
   } spc_work_type;

endpackage

### rtl/spc_coef_mem.sv
// Coefficient table: one entry of four Q16.32 coefficients per straw.
// One write port, one read port, registered read data. Uses spc_pkg.
module spc_coef_mem
   import spc_pkg::*;
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [STRAW_AW-1:0] wr_addr,
   input  spc_coef_type        wr_data,
   input  logic                rd_en,
   input  logic [STRAW_AW-1:0] rd_addr,
   output spc_coef_type        rd_data
);

   spc_coef_type coef_ram [NUM_STRAWS];
   spc_coef_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         coef_ram[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= coef_ram[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/spc_horner.sv
// One Horner step: acc = sat(floor(pos * acc / 256) + add0), two stages.
// Multiply stage splits acc into high and low parts; add stage saturates.
// Uses spc_pkg.
module spc_horner
   import spc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  spc_work_type in_work,
   output logic         out_valid,
   input  logic         out_ready,
   output spc_work_type out_work
);

   localparam int PH_W = HI_W + POS_W + 1;
   localparam int PL_W = FRAC_W + POS_W;
   localparam int SHIFT_W = FRAC_W - POS_FRAC;

   typedef struct packed {
      logic [STRAW_W-1:0]      straw;
      logic [POS_W-1:0]        pos;
      logic signed [PH_W-1:0]  prod_hi;
      logic [PL_W-1:0]         prod_lo;
      logic signed [ACC_W-1:0] add0;
      logic signed [ACC_W-1:0] add1;
      logic signed [ACC_W-1:0] add2;
   } spc_mul_type;

   logic         m_valid_ff;
   logic         m_ready;
   spc_mul_type  m_ff;
   spc_mul_type  m_in;
   logic         a_valid_ff;
   logic         a_ready;
   spc_work_type a_ff;
   spc_work_type a_in;

   logic signed [HI_W-1:0]  t_hi;
   logic [FRAC_W-1:0]       t_lo;
   logic [PH_W-FRAC_W:0]    hi_top;
   logic                    hi_ovf;
   logic signed [SUM_W-1:0] prod_sum;
   logic signed [SUM_W-1:0] acc_sum;
   logic [SUM_W-ACC_W:0]    sum_top;

   assign m_ready  = !m_valid_ff || a_ready;
   assign a_ready  = !a_valid_ff || out_ready;
   assign in_ready = m_ready;

   always_comb begin
      t_hi          = in_work.acc[ACC_W-1:FRAC_W];
      t_lo          = in_work.acc[FRAC_W-1:0];
      m_in.straw    = in_work.straw;
      m_in.pos      = in_work.pos;
      m_in.prod_hi  = $signed({1'b0, in_work.pos}) * t_hi;
      m_in.prod_lo  = in_work.pos * t_lo;
      m_in.add0     = in_work.add0;
      m_in.add1     = in_work.add1;
      m_in.add2     = in_work.add2;
   end

   always_comb begin
      // high product outside 32-bit signed range saturates before the add
      hi_top   = m_ff.prod_hi[PH_W-1:FRAC_W-1];
      hi_ovf   = !((&hi_top) || !(|hi_top));
      prod_sum = SUM_W'($signed({m_ff.prod_hi[FRAC_W-1:0], {SHIFT_W{1'b0}}}))
               + SUM_W'($signed({1'b0, m_ff.prod_lo[PL_W-1:POS_FRAC]}));
      acc_sum  = prod_sum + SUM_W'(m_ff.add0);
      sum_top  = acc_sum[SUM_W-1:ACC_W-1];
      a_in.straw = m_ff.straw;
      a_in.pos   = m_ff.pos;
      a_in.add0  = m_ff.add1;
      a_in.add1  = m_ff.add2;
      a_in.add2  = '0;
      if (hi_ovf) begin
         a_in.acc = m_ff.prod_hi[PH_W-1] ? ACC_MIN : ACC_MAX;
      end else if (!((&sum_top) || !(|sum_top))) begin
         a_in.acc = acc_sum[SUM_W-1] ? ACC_MIN : ACC_MAX;
      end else begin
         a_in.acc = acc_sum[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         a_valid_ff <= 1'b0;
      end else begin
         if (m_ready) begin
            m_valid_ff <= in_valid;
         end
         if (a_ready) begin
            a_valid_ff <= m_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (m_ready) begin
         m_ff <= m_in;
      end
      if (a_ready) begin
         a_ff <= a_in;
      end
   end

   assign out_valid = a_valid_ff;
   assign out_work  = a_ff;

endmodule

### rtl/spc_clamp.sv
// Output stage: subtract delta from the position, clamp below zero and above the resolution.
// Holds the result register of the response channel. Uses spc_pkg.
module spc_clamp
   import spc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  spc_work_type     in_work,
   input  logic [RES_W-1:0] resolution,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spc_rsp_type      rsp_data
);

   localparam int TOP_W = RES_W + FRAC_W;

   logic                    rsp_valid_ff;
   spc_rsp_type             rsp_data_ff;
   spc_rsp_type             rsp_data_in;
   logic signed [SUM_W-1:0] corr;
   logic [TOP_W-1:0]        top;

   assign in_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      corr = SUM_W'($signed({1'b0, in_work.pos, {(FRAC_W-POS_FRAC){1'b0}}}))
           - SUM_W'(in_work.acc);
      top  = {resolution, {FRAC_W{1'b0}}};
      rsp_data_in.straw_out  = in_work.straw;
      rsp_data_in.clamp_low  = 1'b0;
      rsp_data_in.clamp_high = 1'b0;
      if (corr[SUM_W-1]) begin
         rsp_data_in.clamp_low = 1'b1;
         rsp_data_in.pixel_pos = '0;
      end else if (corr[SUM_W-2:0] > (SUM_W-1)'(top)) begin
         rsp_data_in.clamp_high = 1'b1;
         rsp_data_in.pixel_pos  = (resolution == '0) ? '0 : resolution - RES_W'(1);
      end else begin
         rsp_data_in.pixel_pos = corr[FRAC_W +: RES_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_ready) begin
         rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.clamp_low && rsp_data.clamp_high))
      else $error("both clamp flags set");

   a_low_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.clamp_low |-> rsp_data.pixel_pos == '0)
      else $error("low clamp with nonzero pixel");

   a_taken_shows: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> rsp_valid)
      else $error("taken item not presented");

endmodule

### rtl/straw_position_correction_unit.sv
// Top level of the straw position correction unit: coefficient table,
// three Horner steps and the clamp/output stage. Uses spc_pkg and all spc_* modules.
//
//   port group   direction   meaning
//   req_*        in          load coefficients or correct a position (valid/ready)
//   rsp_*        out         corrected pixel with clamp flags (valid/ready)
//   csr_*        in          resolution register write, no wait
//
// Accepts one item per cycle while the response side is not stalled; loads and
// corrections share the table's single write and single read port. A correction
// passes the table read and the s1 register at the accepting edge, then three
// two-stage Horner steps and one clamp stage before it reaches rsp_valid.
// Reset is synchronous, clears all valid bits and sets resolution to 512;
// the table holds no reset state. Each stage holds under a stall and empty
// stages still take items, so req_ready drops only when the whole pipe is full.
module straw_position_correction_unit
   import spc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spc_req_type      req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spc_rsp_type      rsp_data,
   input  logic             csr_wr_en,
   input  logic [RES_W-1:0] csr_wr_data
);

   logic [RES_W-1:0]   resolution_ff;
   logic               accept;
   logic               in_table;
   logic               ram_wr_en;
   logic               ram_rd_en;
   spc_coef_type       ram_wr_data;
   spc_coef_type       rd_coef;

   logic               s1_valid_ff;
   logic               s1_ready;
   logic [STRAW_W-1:0] s1_straw_ff;
   logic [POS_W-1:0]   s1_pos_ff;
   logic               s1_hit_ff;
   spc_work_type       head_work;

   logic [3:0]         h_valid;
   logic [3:0]         h_ready;
   spc_work_type       h_work [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         resolution_ff <= RES_RESET;
      end else if (csr_wr_en) begin
         resolution_ff <= csr_wr_data;
      end
   end

   assign s1_ready  = !s1_valid_ff || h_ready[0];
   assign req_ready = s1_ready;
   assign accept    = req_valid && req_ready;
   assign in_table  = 32'(req_data.straw_id) < NUM_STRAWS;
   assign ram_wr_en = accept && (req_data.op == OP_LOAD) && in_table;
   assign ram_rd_en = accept && (req_data.op == OP_CORRECT) && in_table;

   always_comb begin
      ram_wr_data.coef_a = req_data.coef_a;
      ram_wr_data.coef_b = req_data.coef_b;
      ram_wr_data.coef_c = req_data.coef_c;
      ram_wr_data.coef_d = req_data.coef_d;
   end

   spc_coef_mem u_coef_mem (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (STRAW_AW'(req_data.straw_id)),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (STRAW_AW'(req_data.straw_id)),
      .rd_data (rd_coef)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= accept && (req_data.op == OP_CORRECT);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_straw_ff <= req_data.straw_id;
         s1_pos_ff   <= req_data.pos;
         s1_hit_ff   <= in_table;
      end
   end

   // Straws outside the table use zero coefficients
   always_comb begin
      head_work.straw = s1_straw_ff;
      head_work.pos   = s1_pos_ff;
      head_work.acc   = s1_hit_ff ? ACC_W'(rd_coef.coef_d) : '0;
      head_work.add0  = s1_hit_ff ? ACC_W'(rd_coef.coef_c) : '0;
      head_work.add1  = s1_hit_ff ? ACC_W'(rd_coef.coef_b) : '0;
      head_work.add2  = s1_hit_ff ? ACC_W'(rd_coef.coef_a) : '0;
   end

   assign h_valid[0] = s1_valid_ff;
   assign h_work[0]  = head_work;

   for (genvar g = 0; g < 3; g++) begin : g_horner
      spc_horner u_horner (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (h_valid[g]),
         .in_ready  (h_ready[g]),
         .in_work   (h_work[g]),
         .out_valid (h_valid[g+1]),
         .out_ready (h_ready[g+1]),
         .out_work  (h_work[g+1])
      );
   end

   spc_clamp u_clamp (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (h_valid[3]),
      .in_ready   (h_ready[3]),
      .in_work    (h_work[3]),
      .resolution (resolution_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.op == OP_LOAD) |=> !s1_valid_ff)
      else $error("load item entered the correction pipe");

   a_read_enters: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |=> s1_valid_ff)
      else $error("table read without a pipe item");

   a_read_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_ready |=> $stable(rd_coef))
      else $error("coefficients changed under a stall");

endmodule
